[rtl/core/mlk_pkg.sv]
// Package for the Morse letter keyer: payload types, state codes, key patterns
// and the shift helper used by the shift-register modules and the top level.
// No dependencies.
package mlk_pkg;

   localparam int CodeWidth = 8;

   typedef logic [CodeWidth-1:0] code_type;

   // Key patterns, sent from the MSB; each shift keeps the LSB.
   localparam code_type PatDot       = 8'b1011_1111;
   localparam code_type PatGapDot    = 8'b0010_1111;
   localparam code_type PatDash      = 8'b1110_1111;
   localparam code_type PatGapDash   = 8'b0011_1011;
   localparam code_type PatWordSpace = 8'b0000_1111;
   localparam code_type AllOnes      = 8'hFF;
   localparam code_type AllZeros     = 8'h00;

   typedef struct packed {
      logic [CodeWidth-1:0] letter_code;
      logic                 first_of_message;
   } req_type;

   typedef struct packed {
      logic key_on;
      logic last_key;
   } rsp_type;

   // Control for one shift register: load takes priority over shift.
   typedef struct packed {
      logic load;
      logic shift;
   } shift_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   function automatic code_type keep_lsb_shift(input code_type value);
      return {value[CodeWidth-2:0], value[0]};
   endfunction

   function automatic code_type symbol_pattern(input logic dash, input logic with_gap);
      code_type pat;
      if (with_gap) begin
         pat = dash ? PatGapDash : PatGapDot;
      end else begin
         pat = dash ? PatDash : PatDot;
      end
      return pat;
   endfunction

endpackage

[rtl/core/morse_letter_keyer.sv]
// Morse letter keyer top level: sequencer, symbol and key shift registers,
// and the result register. Depends on mlk_pkg, mlk_sym_shift, mlk_key_shift.
//
//   Channel | Ports                          | Direction | Payload
//   request | req_valid, req_ready, req_data | in        | mlk_pkg::req_type
//   result  | rsp_valid, rsp_ready, rsp_data | out       | mlk_pkg::rsp_type
//
// One key unit leaves the key shift register per cycle while the result
// register is not stalled.
// A new letter is taken once the last unit of the previous one is in the
// result register, even if that unit has not been taken yet.
// While sending, a stalled result holds both shift registers in place.
// Reset is synchronous and active high; the block is ready the cycle after.
module morse_letter_keyer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mlk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mlk_pkg::rsp_type rsp_data
);

   mlk_pkg::state_type state_ff;
   mlk_pkg::state_type state_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   mlk_pkg::rsp_type        rsp_data_ff;
   mlk_pkg::rsp_type        rsp_data_in;

   logic                    req_accept;
   logic                    emit;
   logic                    letter_end;
   logic                    is_space;

   mlk_pkg::shift_ctrl_type sym_ctrl;
   mlk_pkg::shift_ctrl_type key_ctrl;
   mlk_pkg::code_type       sym_load_value;
   mlk_pkg::code_type       key_load_value;

   logic                    sym_dash;
   logic                    sym_done;
   logic                    key_bit;
   logic                    key_last;
   logic                    key_empty;

   assign req_accept = req_valid && req_ready;
   assign emit       = (state_ff == mlk_pkg::ST_SEND) && (!rsp_valid_ff || rsp_ready);
   assign letter_end = key_last && sym_done;
   assign is_space   = (req_data.letter_code == mlk_pkg::AllZeros);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlk_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mlk_pkg::ST_SEND;
            end
         end
         mlk_pkg::ST_SEND: begin
            if (emit && letter_end) begin
               state_in = mlk_pkg::ST_IDLE;
            end
         end
         default: state_in = mlk_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ready      = 1'b0;
      sym_ctrl       = '0;
      key_ctrl       = '0;
      sym_load_value = mlk_pkg::AllOnes;
      key_load_value = mlk_pkg::AllOnes;
      unique case (state_ff)
         mlk_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            sym_ctrl.load = req_valid;
            key_ctrl.load = req_valid;
            if (is_space) begin
               sym_load_value = mlk_pkg::AllOnes;
               key_load_value = mlk_pkg::PatWordSpace;
            end else begin
               // The first symbol is taken off at load time.
               sym_load_value = mlk_pkg::keep_lsb_shift(req_data.letter_code);
               key_load_value = mlk_pkg::symbol_pattern(
                  req_data.letter_code[mlk_pkg::CodeWidth-1],
                  !req_data.first_of_message);
            end
         end
         mlk_pkg::ST_SEND: begin
            key_ctrl.shift = emit;
            // At the end of a symbol the next one loads in the same cycle.
            key_ctrl.load  = emit && key_last && !sym_done;
            sym_ctrl.shift = emit && key_last && !sym_done;
            key_load_value = mlk_pkg::symbol_pattern(sym_dash, 1'b0);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (emit) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.key_on   = key_bit;
         rsp_data_in.last_key = letter_end;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlk_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mlk_sym_shift u_sym_shift (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (sym_ctrl),
      .load_value (sym_load_value),
      .sym_dash   (sym_dash),
      .sym_done   (sym_done)
   );

   mlk_key_shift u_key_shift (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (key_ctrl),
      .load_value (key_load_value),
      .key_bit    (key_bit),
      .key_last   (key_last),
      .key_empty  (key_empty)
   );

   // While sending, the key register always holds at least one unit.
   a_key_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlk_pkg::ST_SEND) |-> !key_empty)
      else $error("key register empty while sending");

   // An accepted transaction starts a letter on the next cycle.
   a_accept_sends: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == mlk_pkg::ST_SEND))
      else $error("accepted letter did not start sending");

   // Finishing a letter leaves its marked last unit in the result register.
   a_end_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlk_pkg::ST_SEND) ##1 (state_ff == mlk_pkg::ST_IDLE)
      |-> (rsp_valid_ff && rsp_data_ff.last_key))
      else $error("letter ended without a marked last unit");

endmodule

[rtl/core/mlk_sym_shift.sv]
// Symbol shift register: holds the dots and dashes of a letter still to send.
// Depends on mlk_pkg.
module mlk_sym_shift (
   input  logic                   clock,
   input  logic                   reset,
   input  mlk_pkg::shift_ctrl_type ctrl,
   input  mlk_pkg::code_type      load_value,
   output logic                   sym_dash,
   output logic                   sym_done
);

   mlk_pkg::code_type symbol_shift_ff;
   mlk_pkg::code_type symbol_shift_in;

   always_comb begin
      priority if (ctrl.load) begin
         symbol_shift_in = load_value;
      end else if (ctrl.shift) begin
         symbol_shift_in = mlk_pkg::keep_lsb_shift(symbol_shift_ff);
      end else begin
         symbol_shift_in = symbol_shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_shift_ff <= mlk_pkg::AllOnes;
      end else begin
         symbol_shift_ff <= symbol_shift_in;
      end
   end

   assign sym_dash = symbol_shift_ff[mlk_pkg::CodeWidth-1];
   // Once only fill bits remain the register reads all zeros or all ones.
   assign sym_done = (symbol_shift_ff == mlk_pkg::AllZeros) ||
                     (symbol_shift_ff == mlk_pkg::AllOnes);

endmodule

[rtl/core/mlk_key_shift.sv]
// Key shift register: sends a symbol's key units, one bit per cycle on shift.
// Depends on mlk_pkg.
module mlk_key_shift (
   input  logic                   clock,
   input  logic                   reset,
   input  mlk_pkg::shift_ctrl_type ctrl,
   input  mlk_pkg::code_type      load_value,
   output logic                   key_bit,
   output logic                   key_last,
   output logic                   key_empty
);

   mlk_pkg::code_type key_shift_ff;
   mlk_pkg::code_type key_shift_in;
   mlk_pkg::code_type key_shifted;

   assign key_shifted = mlk_pkg::keep_lsb_shift(key_shift_ff);

   always_comb begin
      priority if (ctrl.load) begin
         key_shift_in = load_value;
      end else if (ctrl.shift) begin
         key_shift_in = key_shifted;
      end else begin
         key_shift_in = key_shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_shift_ff <= mlk_pkg::AllOnes;
      end else begin
         key_shift_ff <= key_shift_in;
      end
   end

   assign key_bit   = key_shift_ff[mlk_pkg::CodeWidth-1];
   // The current unit ends the symbol when the register turns all ones after it.
   assign key_last  = (key_shifted == mlk_pkg::AllOnes);
   assign key_empty = (key_shift_ff == mlk_pkg::AllOnes);

endmodule
